/* hw/rtl/ampd_pkg.sv */
package ampd_pkg;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_PULL = 1'b1;

   localparam logic [1:0] RK_SUMMARY = 2'd0;
   localparam logic [1:0] RK_PEAK    = 2'd1;
   localparam logic [1:0] RK_NONE    = 2'd2;

   localparam logic [6:0] SCALE_LIMIT_RESET = 7'd20;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] sample;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [9:0]  peak_index;
      logic [10:0] peak_count;
      logic [5:0]  chosen_scale;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP0,
      ST_PREP1,
      ST_RDI,
      ST_GETI,
      ST_NB,
      ST_MUL,
      ST_CMP,
      ST_MARK,
      ST_SELM,
      ST_SELC,
      ST_CNTA,
      ST_CNTB,
      ST_PULA,
      ST_PULB,
      ST_OUT
   } state_type;

endpackage

/* hw/rtl/ampd_scale_cell.sv */
module ampd_scale_cell
   import ampd_pkg::*;
#(
   parameter int CNT_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctrl_type    ctrl,
   input  logic             inc,
   input  logic [CNT_W-1:0] shift_in,
   output logic [CNT_W-1:0] count_out
);

   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.shift) begin
         count_in = shift_in;
      end else if (inc) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count_out = count_ff;

endmodule

/* hw/rtl/ampd_peak_detector.sv */
// channel   dir  handshake            payload
// req       in   req_valid/req_stall  req_data  (load sample or pull peak)
// rsp       out  rsp_valid/rsp_stall  rsp_data  (summary, peak or none)
// csr       in   csr_we               csr_data  (scale_limit)
// A load that is not last leaves the block idle for the next sample. A last
// sample starts the pass: the neighbor compares (one memory read and one
// shared multiply pair per compare), then the scale chain, then the count.
// A pull scans the mask memory one index at a time. Reset is synchronous;
// req_stall is high while the pass or a pull runs, or a word waits to leave.
module ampd_peak_detector
   import ampd_pkg::*;
#(
   parameter int MAX_SAMPLES = 1024,
   parameter int MAX_SCALES  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [6:0] csr_data
);

   localparam int AW  = $clog2(MAX_SAMPLES);
   localparam int IW  = AW + 1;
   localparam int SJW = (MAX_SCALES > 1) ? $clog2(MAX_SCALES) : 1;
   localparam int SB  = SAMPLE_BITS;
   localparam int SUW = SB + IW;
   localparam int XW  = SB + 2 * IW;
   localparam int PW0 = SB + 2 * IW + 1;
   localparam int KW  = SB + 2 * IW + 6;
   localparam int SW  = 3 * IW + 1;
   localparam int CW  = SB + 3 * IW + 8;
   localparam int WW  = 2 * IW + 2;

   state_type state_ff, state_in;

   logic signed [SB-1:0]  smem [MAX_SAMPLES];
   logic [MAX_SCALES-1:0] mmem [MAX_SAMPLES];
   logic signed [SB-1:0]  srd_ff;
   logic [MAX_SCALES-1:0] mrd_ff;
   logic [AW-1:0]         sraddr, mraddr;
   logic                  swe, mwe;
   logic [AW-1:0]         swaddr;
   logic signed [SB-1:0]  swdata;
   logic [MAX_SCALES-1:0] mwdata;

   logic [6:0]            lim_cfg_ff, lim_cfg_in;
   logic [SJW-1:0]        lim_m1_ff, lim_m1_in;
   logic [IW-1:0]         count_ff, count_in;
   logic signed [SUW-1:0] sum_ff, sum_in;
   logic signed [XW-1:0]  sumix_ff, sumix_in;
   logic                  held_ff, held_in;
   logic                  ovf_ff, ovf_in;
   logic [IW-1:0]         total_ff, total_in;
   logic [IW-1:0]         cursor_ff, cursor_in;
   logic [SJW-1:0]        win_ff, win_in;
   logic signed [PW0-1:0] p_ff, p_in;
   logic [2*IW-1:0]       nn_ff, nn_in;
   logic signed [SW-1:0]  s_ff, s_in;
   logic signed [KW-1:0]  k3_ff, k3_in;
   logic [IW-1:0]         i_ff, i_in;
   logic [SJW-1:0]        j_ff, j_in;
   logic                  phase_ff, phase_in;
   logic                  ok_ff, ok_in;
   logic signed [SB-1:0]  xi_ff, xi_in;
   logic [MAX_SCALES-1:0] mask_ff, mask_in;
   logic signed [CW-1:0]  lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic signed [WW-1:0]  wprod_ff, wprod_in, best_ff, best_in;
   rsp_type               pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  req_take;
   logic [IW-1:0]         eff_count;
   logic [23:0]           sample_wide;
   logic signed [SB-1:0]  sample_v;
   logic [IW:0]           lag, right_pos;
   logic [7:0]            lim_eff;
   logic [MAX_SCALES-1:0] peak_mask;
   logic                  is_peak;
   logic [IW-1:0]         cnt0;
   logic [IW-1:0]         cell_cnt [MAX_SCALES];
   logic [MAX_SCALES-1:0] cell_inc;
   cell_ctrl_type         cell_ctrl;

   assign req_take    = req_valid && (state_ff == ST_IDLE);
   assign req_stall   = (state_ff != ST_IDLE);
   assign eff_count   = held_ff ? '0 : count_ff;
   assign sample_wide = {8'd0, req_data.sample};
   assign sample_v    = sample_wide[SB-1:0];
   assign lag         = (IW + 1)'(j_ff) + (IW + 1)'(1);
   assign right_pos   = (IW + 1)'(i_ff) + lag;

   always_comb begin
      if (lim_cfg_ff == 7'd0) begin
         lim_eff = 8'd1;
      end else if ({1'b0, lim_cfg_ff} > 8'(MAX_SCALES)) begin
         lim_eff = 8'(MAX_SCALES);
      end else begin
         lim_eff = {1'b0, lim_cfg_ff};
      end
   end

   always_comb begin
      for (int b = 0; b < MAX_SCALES; b++) begin
         peak_mask[b] = (SJW'(b) <= win_ff);
      end
   end
   assign is_peak = ((mrd_ff & peak_mask) == peak_mask);

   // scale count chain: shifts toward cell 0 during selection
   for (genvar k = 0; k < MAX_SCALES; k++) begin : g_cell
      logic [IW-1:0] nbr;
      if (k == MAX_SCALES - 1) begin : g_end
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = cell_cnt[k+1];
      end
      assign cell_inc[k] = (state_ff == ST_MARK) && ok_ff && (j_ff == SJW'(k));
      ampd_scale_cell #(.CNT_W(IW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .inc       (cell_inc[k]),
         .shift_in  (nbr),
         .count_out (cell_cnt[k])
      );
   end
   assign cnt0 = cell_cnt[0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.kind == KIND_PULL) begin
                  state_in = held_ff ? ST_PULA : ST_OUT;
               end else if (req_data.last) begin
                  state_in = ST_PREP0;
               end
            end
         end
         ST_PREP0: state_in = ST_PREP1;
         ST_PREP1: state_in = ST_RDI;
         ST_RDI:   state_in = ST_GETI;
         ST_GETI:  state_in = ST_NB;
         ST_NB: begin
            if (!phase_ff) begin
               if (right_pos < (IW + 1)'(count_ff)) state_in = ST_MUL;
            end else begin
               state_in = ((IW + 1)'(i_ff) >= lag) ? ST_MUL : ST_MARK;
            end
         end
         ST_MUL:   state_in = ST_CMP;
         ST_CMP:   state_in = phase_ff ? ST_MARK : ST_NB;
         ST_MARK: begin
            if (j_ff == lim_m1_ff) begin
               state_in = (i_ff == count_ff - IW'(1)) ? ST_SELM : ST_RDI;
            end else begin
               state_in = ST_NB;
            end
         end
         ST_SELM:  state_in = ST_SELC;
         ST_SELC:  state_in = (j_ff == lim_m1_ff) ? ST_CNTA : ST_SELM;
         ST_CNTA:  state_in = ST_CNTB;
         ST_CNTB:  state_in = (i_ff == count_ff - IW'(1)) ? ST_OUT : ST_CNTA;
         ST_PULA:  state_in = (cursor_ff >= count_ff) ? ST_OUT : ST_PULB;
         ST_PULB:  state_in = is_peak ? ST_OUT : ST_PULA;
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lim_cfg_in = csr_we ? csr_data : lim_cfg_ff;
      lim_m1_in  = lim_m1_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      sumix_in   = sumix_ff;
      held_in    = held_ff;
      ovf_in     = ovf_ff;
      total_in   = total_ff;
      cursor_in  = cursor_ff;
      win_in     = win_ff;
      p_in       = p_ff;
      nn_in      = nn_ff;
      s_in       = s_ff;
      k3_in      = k3_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      phase_in   = phase_ff;
      ok_in      = ok_ff;
      xi_in      = xi_ff;
      mask_in    = mask_ff;
      lhs_in     = lhs_ff;
      rhs_in     = rhs_ff;
      wprod_in   = wprod_ff;
      best_in    = best_ff;
      pend_in    = pend_ff;
      sraddr     = i_ff[AW-1:0];
      mraddr     = i_ff[AW-1:0];
      swe        = 1'b0;
      swaddr     = eff_count[AW-1:0];
      swdata     = sample_v;
      mwe        = 1'b0;
      mwdata     = mask_ff;
      cell_ctrl  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_data.kind == KIND_LOAD) begin
               held_in   = 1'b0;
               cursor_in = '0;
               total_in  = '0;
               if (held_ff) begin
                  ovf_in   = 1'b0;
                  count_in = '0;
                  sum_in   = '0;
                  sumix_in = '0;
               end
               if (eff_count < IW'(MAX_SAMPLES)) begin
                  swe      = 1'b1;
                  count_in = eff_count + IW'(1);
                  sum_in   = (held_ff ? '0 : sum_ff) + SUW'(sample_v);
                  sumix_in = (held_ff ? '0 : sumix_ff)
                           + XW'(sample_v * $signed({1'b0, eff_count}));
               end else begin
                  ovf_in = 1'b1;
               end
            end else if (req_take) begin
               pend_in = '0;
               pend_in.result_kind = RK_NONE;
            end
         end
         ST_PREP0: begin
            cell_ctrl.clear = 1'b1;
            lim_m1_in = SJW'(lim_eff - 8'd1);
            p_in  = PW0'($signed({1'b0, count_ff - IW'(1)}) * sum_ff);
            nn_in = (2 * IW)'(count_ff) * (2 * IW)'(count_ff);
            i_in  = '0;
         end
         ST_PREP1: begin
            s_in  = SW'($signed({1'b0, (3 * IW)'(count_ff) * (3 * IW)'(nn_ff - (2 * IW)'(1))}));
            k3_in = KW'(3) * (KW'(2) * (KW'(2) * KW'(sumix_ff) - KW'(p_ff)));
         end
         ST_RDI: begin
            sraddr   = i_ff[AW-1:0];
            mask_in  = '0;
            j_in     = '0;
            phase_in = 1'b0;
            ok_in    = 1'b1;
         end
         ST_GETI: xi_in = srd_ff;
         ST_NB: begin
            if (!phase_ff) begin
               sraddr = right_pos[AW-1:0];
               if (right_pos >= (IW + 1)'(count_ff)) phase_in = 1'b1;
            end else begin
               sraddr = AW'((IW + 1)'(i_ff) - lag);
            end
         end
         ST_MUL: begin
            lhs_in = CW'((SB + 1)'(xi_ff) - (SB + 1)'(srd_ff)) * CW'(s_ff);
            rhs_in = CW'(k3_ff) * (phase_ff ? CW'($signed({1'b0, lag}))
                                            : -CW'($signed({1'b0, lag})));
         end
         ST_CMP: begin
            if (!(lhs_ff > rhs_ff)) ok_in = 1'b0;
            phase_in = 1'b1;
         end
         ST_MARK: begin
            mask_in[j_ff] = ok_ff;
            ok_in    = 1'b1;
            phase_in = 1'b0;
            if (j_ff == lim_m1_ff) begin
               mwe    = 1'b1;
               mwdata = mask_in;
               i_in   = i_ff + IW'(1);
               j_in   = '0;
            end else begin
               j_in = j_ff + SJW'(1);
            end
         end
         ST_SELM: begin
            wprod_in = WW'($signed({1'b0, cnt0})
                     * ($signed({1'b0, count_ff >> 1}) - $signed({1'b0, IW'(j_ff)})));
         end
         ST_SELC: begin
            cell_ctrl.shift = 1'b1;
            if (j_ff == '0 || wprod_ff > best_ff) begin
               best_in = wprod_ff;
               win_in  = j_ff;
            end
            j_in = j_ff + SJW'(1);
            i_in = '0;
            total_in = '0;
         end
         ST_CNTA: mraddr = i_ff[AW-1:0];
         ST_CNTB: begin
            if (is_peak) total_in = total_ff + IW'(1);
            i_in = i_ff + IW'(1);
            pend_in.result_kind  = RK_SUMMARY;
            pend_in.peak_index   = '0;
            pend_in.peak_count   = 11'(total_in);
            pend_in.chosen_scale = 6'(win_ff);
            pend_in.overflow     = ovf_ff;
            held_in   = 1'b1;
            cursor_in = '0;
         end
         ST_PULA: begin
            mraddr = cursor_ff[AW-1:0];
            pend_in.result_kind  = RK_NONE;
            pend_in.peak_index   = '0;
            pend_in.peak_count   = 11'(total_ff);
            pend_in.chosen_scale = 6'(win_ff);
            pend_in.overflow     = ovf_ff;
         end
         ST_PULB: begin
            cursor_in = cursor_ff + IW'(1);
            if (is_peak) begin
               pend_in.result_kind = RK_PEAK;
               pend_in.peak_index  = 10'(cursor_ff);
            end
         end
         ST_OUT: ;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in = 1'b1;
         rsp_in       = pend_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (swe) smem[swaddr] <= swdata;
      if (mwe) mmem[i_ff[AW-1:0]] <= mwdata;
      srd_ff <= smem[sraddr];
      mrd_ff <= mmem[mraddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lim_cfg_ff   <= SCALE_LIMIT_RESET;
         lim_m1_ff    <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sumix_ff     <= '0;
         held_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         total_ff     <= '0;
         cursor_ff    <= '0;
         win_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         phase_ff     <= 1'b0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lim_cfg_ff   <= lim_cfg_in;
         lim_m1_ff    <= lim_m1_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sumix_ff     <= sumix_in;
         held_ff      <= held_in;
         ovf_ff       <= ovf_in;
         total_ff     <= total_in;
         cursor_ff    <= cursor_in;
         win_ff       <= win_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         phase_ff     <= phase_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      nn_ff    <= nn_in;
      s_ff     <= s_in;
      k3_ff    <= k3_in;
      xi_ff    <= xi_in;
      mask_ff  <= mask_in;
      lhs_ff   <= lhs_in;
      rhs_ff   <= rhs_in;
      wprod_ff <= wprod_in;
      best_ff  <= best_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* tb/sv/tb_ampd_peak_detector.sv */
`timescale 1ns / 1ps

module tb_ampd_peak_detector;
   import ampd_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_we;
   logic [6:0] csr_data;

   ampd_peak_detector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_data  (csr_data)
   );

   localparam int CAPACITY = 1024;
   localparam int SCALES   = 64;

   req_type pending_words[$];
   rsp_type expected_words[$];
   int      errors = 0;
   bit      quiet;
   bit      hold_kick;
   bit      hold_done;
   int      hold_left;

   // detector model state
   longint       sample_mem[CAPACITY];
   logic [63:0]  mask_mem[CAPACITY];
   int           hits[SCALES];
   int           set_len;
   longint       sum_s;
   longint       sum_is;
   longint       s2;
   longint       kt;
   int           win_scale;
   int           cursor;
   bit           ovf;
   bit           held;
   int           peak_total;
   logic [6:0]   scale_reg;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic bit above(int a, int b);
      longint lhs;
      longint rhs;
      lhs = (sample_mem[a] - sample_mem[b]) * s2;
      rhs = kt * longint'(a - b);
      return lhs > rhs;
   endfunction

   function automatic bit peak_at(int i);
      logic [63:0] m;
      m = (win_scale >= 63) ? '1 : ((64'd1 << (win_scale + 1)) - 64'd1);
      return (mask_mem[i] & m) == m;
   endfunction

   function automatic void detect_peaks();
      int     lim;
      int     lag;
      bit     ok;
      longint n;
      longint best;
      longint v;
      lim = scale_reg;
      if (lim < 1) lim = 1;
      if (lim > SCALES) lim = SCALES;
      n = set_len;
      s2 = n * (n * n - 1) / 3;
      kt = 2 * (2 * sum_is - (n - 1) * sum_s);
      for (int j = 0; j < SCALES; j++) hits[j] = 0;
      for (int i = 0; i < set_len; i++) begin
         mask_mem[i] = '0;
         for (int j = 0; j < lim; j++) begin
            lag = j + 1;
            ok = 1'b1;
            if (i + lag < set_len && !above(i, i + lag)) ok = 1'b0;
            if (i >= lag && !above(i, i - lag)) ok = 1'b0;
            if (ok) begin
               mask_mem[i][j] = 1'b1;
               hits[j]++;
            end
         end
      end
      win_scale = 0;
      best = longint'(hits[0]) * (n / 2);
      for (int j = 1; j < lim; j++) begin
         v = longint'(hits[j]) * ((n / 2) - j);
         if (v > best) begin
            best = v;
            win_scale = j;
         end
      end
      peak_total = 0;
      for (int i = 0; i < set_len; i++)
         if (peak_at(i)) peak_total++;
      cursor = 0;
      held = 1'b1;
   endfunction

   function automatic void model_reset();
      held = 1'b0;
      set_len = 0;
      sum_s = 0;
      sum_is = 0;
      win_scale = 0;
      cursor = 0;
      ovf = 1'b0;
      peak_total = 0;
   endfunction

   function automatic void predict_word(req_type w);
      rsp_type r;
      int i;
      r = '0;
      if (w.kind == KIND_LOAD) begin
         if (held) begin
            held = 1'b0;
            set_len = 0;
            sum_s = 0;
            sum_is = 0;
            cursor = 0;
            ovf = 1'b0;
            peak_total = 0;
         end
         if (set_len < CAPACITY) begin
            sample_mem[set_len] = longint'(w.sample);
            sum_s += longint'(w.sample);
            sum_is += longint'(w.sample) * set_len;
            set_len++;
         end else begin
            ovf = 1'b1;
         end
         if (!w.last) return;
         detect_peaks();
         r.result_kind = RK_SUMMARY;
      end else begin
         r.result_kind = RK_NONE;
         if (!held) begin
            expected_words.push_back(r);
            return;
         end
         for (i = cursor; i < set_len; i++) begin
            if (peak_at(i)) begin
               r.result_kind = RK_PEAK;
               r.peak_index = i[9:0];
               break;
            end
         end
         cursor = (i < set_len) ? i + 1 : set_len;
      end
      r.peak_count = peak_total[10:0];
      r.chosen_scale = win_scale[5:0];
      r.overflow = ovf;
      expected_words.push_back(r);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         model_reset();
      end else begin
         if (req_valid && !req_stall) predict_word(req_data);
         if (!req_valid || !req_stall) begin
            if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 35)) begin
               req_valid <= 1'b1;
               req_data <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word kind %0d", rsp_data.result_kind);
               errors++;
            end else begin
               rsp_type e;
               e = expected_words.pop_front();
               if (e.result_kind !== rsp_data.result_kind) begin
                  $error("result_kind exp %0d got %0d", e.result_kind, rsp_data.result_kind);
                  errors++;
               end
               if (e.peak_index !== rsp_data.peak_index) begin
                  $error("peak_index exp %0d got %0d", e.peak_index, rsp_data.peak_index);
                  errors++;
               end
               if (e.peak_count !== rsp_data.peak_count) begin
                  $error("peak_count exp %0d got %0d", e.peak_count, rsp_data.peak_count);
                  errors++;
               end
               if (e.chosen_scale !== rsp_data.chosen_scale) begin
                  $error("chosen_scale exp %0d got %0d", e.chosen_scale,
                         rsp_data.chosen_scale);
                  errors++;
               end
               if (e.overflow !== rsp_data.overflow) begin
                  $error("overflow exp %0d got %0d", e.overflow, rsp_data.overflow);
                  errors++;
               end
            end
         end
         if (hold_kick && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 35);
         end
      end
   end

   function automatic req_type mk(logic kind, logic signed [15:0] s, logic lst);
      req_type w;
      w.kind = kind;
      w.sample = s;
      w.last = lst;
      return w;
   endfunction

   task automatic drain();
      while (pending_words.size() > 0 || expected_words.size() > 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_scale(logic [6:0] v);
      drain();
      csr_we <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      scale_reg = v;
   endtask

   task automatic queue_set(int len, int pulls);
      int slope;
      int base;
      int v;
      slope = $urandom_range(2) == 0 ? int'($urandom_range(600)) - 300 : 0;
      base = int'($urandom_range(65535)) - 32768;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(3) == 0) v = int'($urandom_range(65535)) - 32768;
         else v = base + slope * i + int'($urandom_range(4000)) - 2000;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         pending_words.push_back(mk(KIND_LOAD, v[15:0], i == len - 1));
      end
      for (int i = 0; i < pulls; i++)
         pending_words.push_back(mk(KIND_PULL, 16'($urandom), 1'($urandom)));
   endtask

   initial begin
      int len;
      quiet = 1'b0;
      hold_kick = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_data = '0;
      scale_reg = SCALE_LIMIT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      pending_words.push_back(mk(KIND_PULL, 16'h0000, 1'b1));
      pending_words.push_back(mk(KIND_LOAD, 16'sh7fff, 1'b1));
      pending_words.push_back(mk(KIND_PULL, 16'h0000, 1'b0));
      pending_words.push_back(mk(KIND_PULL, 16'hffff, 1'b1));
      pending_words.push_back(mk(KIND_LOAD, 16'sh8000, 1'b0));
      pending_words.push_back(mk(KIND_LOAD, 16'sh7fff, 1'b0));
      pending_words.push_back(mk(KIND_LOAD, 16'sh8000, 1'b0));
      pending_words.push_back(mk(KIND_LOAD, 16'sh7fff, 1'b0));
      pending_words.push_back(mk(KIND_LOAD, 16'sd0, 1'b0));
      pending_words.push_back(mk(KIND_LOAD, 16'sh7fff, 1'b1));
      repeat (5) pending_words.push_back(mk(KIND_PULL, 16'h0000, 1'b0));
      set_scale(7'd0);
      queue_set(9, 7);
      set_scale(7'd127);
      queue_set(12, 8);
      set_scale(7'd64);
      queue_set(70, 4);
      set_scale(7'd65);
      queue_set(5, 5);

      // capacity overflow, no idling on either side
      set_scale(7'd1);
      quiet = 1'b1;
      queue_set(1026, 4);
      drain();
      quiet = 1'b0;

      // long receiver hold while sender keeps pushing
      set_scale(7'd3);
      queue_set(10, 8);
      hold_kick = 1'b1;
      queue_set(8, 6);

      // random
      for (int ph = 0; ph < 4; ph++) begin
         set_scale(7'($urandom_range(24) + 1));
         len = int'($urandom_range(15)) + 1;
         queue_set(len, len / 2 + int'($urandom_range(3)));
      end
      drain();
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* ampd_peak_detector.f */
hw/rtl/ampd_pkg.sv
hw/rtl/ampd_scale_cell.sv
hw/rtl/ampd_peak_detector.sv
tb/sv/tb_ampd_peak_detector.sv
